// ===== design/can_register_request_server_top_defines.svh =====
// Assertion macros for the CAN register request server.
// Used by the modules that check their own logic; they expect clk and rst_n in scope.
`ifndef CAN_REGISTER_REQUEST_SERVER_TOP_DEFINES_SVH
`define CAN_REGISTER_REQUEST_SERVER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CRRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CRRS_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);
`else
`define CRRS_ASSERT(label, prop, msg)
`define CRRS_ASSERT_NEXT(label, trig, prop, msg)
`endif
`endif

// ===== design/crrs_pkg.sv =====
// Package for the CAN register request server: beat types, request stage type,
// memory request type and the function and reply codes. No dependencies.
package crrs_pkg;

    localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
    localparam logic [7:0]  FN_WRITE_SINGLE = 8'h06;
    localparam logic [7:0]  FN_WRITE_MULTI  = 8'h10;
    localparam logic [7:0]  EXC_FLAG        = 8'h80;
    localparam logic [7:0]  EXC_BAD_ADDRESS = 8'h02;
    localparam logic [10:0] REPLY_BIT       = 11'h100;
    localparam logic [3:0]  LEN_EXCEPTION   = 4'd2;
    localparam logic [3:0]  LEN_NORMAL      = 4'd5;
    localparam logic [7:0]  NODE_ID_RESET   = 8'd1;

    typedef struct packed {
        logic [7:0]  rx_function;
        logic [15:0] rx_address;
        logic [7:0]  rx_value_high;
        logic [7:0]  rx_value_low;
    } crrs_in_t;

    typedef struct packed {
        logic [10:0] tx_identifier;
        logic [3:0]  tx_length;
        logic [7:0]  tx_byte_zero;
        logic [7:0]  tx_byte_one;
        logic [7:0]  tx_byte_two;
        logic [7:0]  tx_byte_three;
        logic [7:0]  tx_byte_four;
    } crrs_out_t;

    typedef struct packed {
        logic     in_range;
        crrs_in_t req;
    } crrs_stage_t;

    typedef struct packed {
        logic        wr_en;
        logic        rd_en;
        logic [15:0] addr;
        logic [15:0] wdata;
    } crrs_mem_req_t;

endpackage

// ===== design/crrs_regfile.sv =====
// Register file of the request server: one memory with a registered read port
// and a clearing pass after reset. Depends on crrs_pkg and the defines header.
`include "can_register_request_server_top_defines.svh"

module crrs_regfile
    import crrs_pkg::*;
#(
    parameter int REGISTER_COUNT = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  crrs_mem_req_t mem_req,
    output logic [15:0]   rdata,
    output logic          busy
);

    localparam int AW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
    localparam logic [AW-1:0] LAST_INDEX = AW'(REGISTER_COUNT - 1);

    logic [15:0]   mem_reg [REGISTER_COUNT];
    logic [15:0]   rdata_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;
    logic          busy_reg;
    logic          busy_next;
    logic [AW-1:0] index;

    assign index = mem_req.addr[AW-1:0];

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        busy_next    = busy_reg;
        if (busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == LAST_INDEX)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            busy_reg    <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem_reg[clr_cnt_reg] <= '0;
        end
        else if (mem_req.wr_en)
        begin
            mem_reg[index] <= mem_req.wdata;
        end
        if (mem_req.rd_en)
        begin
            rdata_reg <= mem_reg[index];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = busy_reg;

    `CRRS_ASSERT(a_one_access, !(mem_req.wr_en && mem_req.rd_en), "Read and write in one cycle.")
    `CRRS_ASSERT(a_no_access_clearing, !(busy_reg && (mem_req.wr_en || mem_req.rd_en)),
                 "Memory access during the clearing pass.")

endmodule

// ===== design/crrs_reply.sv =====
// Reply formation: builds the reply beat from a registered request and the
// register read data. Depends on crrs_pkg.
module crrs_reply
    import crrs_pkg::*;
(
    input  crrs_stage_t stage,
    input  logic [15:0] rdata,
    input  logic [7:0]  node_id,
    output logic        has_reply,
    output crrs_out_t   reply
);

    always_comb
    begin
        has_reply           = 1'b0;
        reply.tx_identifier = REPLY_BIT | {3'b000, node_id};
        reply.tx_length     = LEN_NORMAL;
        reply.tx_byte_zero  = stage.req.rx_function;
        reply.tx_byte_one   = stage.req.rx_address[15:8];
        reply.tx_byte_two   = stage.req.rx_address[7:0];
        reply.tx_byte_three = stage.req.rx_value_high;
        reply.tx_byte_four  = stage.req.rx_value_low;
        if (!stage.in_range)
        begin
            has_reply           = 1'b1;
            reply.tx_length     = LEN_EXCEPTION;
            reply.tx_byte_zero  = EXC_FLAG | stage.req.rx_function;
            reply.tx_byte_one   = EXC_BAD_ADDRESS;
            reply.tx_byte_two   = '0;
            reply.tx_byte_three = '0;
            reply.tx_byte_four  = '0;
        end
        else
        begin
            case (stage.req.rx_function)
                FN_READ_HOLDING:
                begin
                    has_reply           = 1'b1;
                    reply.tx_byte_three = rdata[15:8];
                    reply.tx_byte_four  = rdata[7:0];
                end
                FN_WRITE_SINGLE, FN_WRITE_MULTI:
                begin
                    has_reply = 1'b1;
                end
                default:
                begin
                    has_reply = 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== design/can_register_request_server_top.sv =====
// Top level of the CAN register request server: request register, node id
// register, reply register and handshakes. Depends on crrs_pkg, crrs_regfile,
// crrs_reply and the defines header.
//
// The block takes one request beat per clock cycle while req_stall is low. The
// register file read and the request stage are registered at acceptance; the
// reply beat is formed from them into the output register once it is free.
// Requests with an unknown function code and an address in range give no reply.
// A stalled reply beat holds the request stage behind it; outside the clearing
// pass req_stall rises only when both are full. After reset the register file
// is cleared one entry per cycle; req_stall is high during that pass. The user
// writes the node id register through cfg_wr_en only while no beat is in
// flight; the block itself does not enforce this.
`include "can_register_request_server_top_defines.svh"

module can_register_request_server_top
    import crrs_pkg::*;
#(
    parameter int REGISTER_COUNT = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  crrs_in_t  req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output crrs_out_t rsp,
    input  logic      cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    localparam logic [16:0] REG_LIMIT = 17'(REGISTER_COUNT);

    logic          busy;
    logic          req_accept;
    logic          in_range;
    logic          is_read;
    logic          is_write;
    crrs_mem_req_t mem_req;
    logic [15:0]   rdata;

    logic          s1_valid_reg;
    logic          s1_valid_next;
    crrs_stage_t   s1_reg;
    logic          s1_move;
    logic          has_reply;
    crrs_out_t     reply;

    logic          out_valid_reg;
    logic          out_valid_next;
    crrs_out_t     out_reg;
    logic          out_free;

    logic [7:0]    node_id_reg;

    assign in_range = ({1'b0, req.rx_address} < REG_LIMIT);
    assign is_read  = (req.rx_function == FN_READ_HOLDING);
    assign is_write = (req.rx_function == FN_WRITE_SINGLE) ||
                      (req.rx_function == FN_WRITE_MULTI);

    assign out_free   = !out_valid_reg || !rsp_stall;
    assign s1_move    = s1_valid_reg && (!has_reply || out_free);
    assign req_stall  = busy || (s1_valid_reg && !s1_move);
    assign req_accept = req_valid && !req_stall;

    always_comb
    begin
        mem_req.wr_en = req_accept && in_range && is_write;
        mem_req.rd_en = req_accept && in_range && is_read;
        mem_req.addr  = req.rx_address;
        mem_req.wdata = {req.rx_value_high, req.rx_value_low};
    end

    crrs_regfile #(
        .REGISTER_COUNT (REGISTER_COUNT)
    ) u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .mem_req (mem_req),
        .rdata   (rdata),
        .busy    (busy)
    );

    crrs_reply u_reply (
        .stage     (s1_reg),
        .rdata     (rdata),
        .node_id   (node_id_reg),
        .has_reply (has_reply),
        .reply     (reply)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_move && has_reply)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            node_id_reg   <= NODE_ID_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                node_id_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_reg.in_range <= in_range;
            s1_reg.req      <= req;
        end
        if (s1_move && has_reply)
        begin
            out_reg <= reply;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `CRRS_ASSERT(a_no_accept_clearing, !(busy && req_accept), "Beat accepted while clearing.")
    `CRRS_ASSERT_NEXT(a_accept_fills_stage, req_accept, s1_valid_reg,
                      "Accepted beat missing from the request stage.")
    `CRRS_ASSERT(a_reply_length, !rsp_valid || (rsp.tx_length == LEN_EXCEPTION) ||
                 (rsp.tx_length == LEN_NORMAL), "Reply beat with a bad length.")
    `CRRS_ASSERT_NEXT(a_silent_request_drains, s1_valid_reg && !has_reply && !req_accept,
                      !s1_valid_reg, "Request without reply stuck in the stage.")

endmodule
